// ----- rtl/anhc_pkg.sv -----
// ----------------------------------------------------------------------------
// anhc_pkg
// Shared types and constants of the ARP next-hop cache: transaction payloads,
// operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package anhc_pkg;

  localparam int unsigned EntriesDefault = 8;

  localparam int unsigned IpW     = 32;
  localparam int unsigned MacW    = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // operation codes
  localparam logic OpResolve = 1'b0;
  localparam logic OpLearn   = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLocalIp    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSubnetMask = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGatewayIp  = 2'd2;

  typedef struct packed {
    logic            operation;
    logic [IpW-1:0]  peer_ip;
    logic [MacW-1:0] peer_mac;
    logic [IpW-1:0]  target_ip;
  } item_t;

  typedef struct packed {
    logic            hit;
    logic [MacW-1:0] found_mac;
    logic [IpW-1:0]  next_hop_ip;
    logic            request_needed;
    logic            stored;
  } result_t;

  typedef struct packed {
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } entry_t;

endpackage

// ----- rtl/arp_next_hop_cache_unit.sv -----
// ----------------------------------------------------------------------------
// arp_next_hop_cache_unit
// Resolves a destination to its next-hop MAC through a small ARP cache and
// learns entries from ARP replies, with round-robin replacement.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The cache lives
// in a synchronous memory with a single registered read port and is scanned
// one entry per cycle, lowest index first, until the first match or, on a
// miss, the last entry. The result appears on result_o for exactly one cycle
// with result_valid_o high and must be taken then: there is no way to hold it
// off. busy drops at the edge that shows the result, so the next transaction
// may start in that same cycle. Per-entry valid bits make the cache read as
// all zero right after reset, so no clearing pass is needed. Configuration
// may only be written while idle.
// ----------------------------------------------------------------------------
module arp_next_hop_cache_unit #(
  parameter int unsigned Entries = anhc_pkg::EntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  anhc_pkg::item_t                item_i,
  output logic                           result_valid_o,
  output anhc_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [anhc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [anhc_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  // configuration
  logic [anhc_pkg::IpW-1:0] local_ip_q, subnet_mask_q, gateway_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q    <= '0;
      subnet_mask_q <= '0;
      gateway_ip_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        anhc_pkg::CfgLocalIp:    local_ip_q    <= cfg_data_i;
        anhc_pkg::CfgSubnetMask: subnet_mask_q <= cfg_data_i;
        anhc_pkg::CfgGatewayIp:  gateway_ip_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and payload registers
  logic                     state_q, state_d;
  anhc_pkg::item_t          item_q, item_d;
  logic [anhc_pkg::IpW-1:0] key_q, key_d;
  logic [IdxW-1:0]          rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]          cmp_idx_q, cmp_idx_d;
  logic                     cmp_v_q, cmp_v_d;
  logic [IdxW-1:0]          wp_q, wp_d;
  logic [Entries-1:0]       valid_q, valid_d;
  logic                     result_valid_q, result_valid_d;
  anhc_pkg::result_t        result_q, result_d;

  // cache memory
  anhc_pkg::entry_t entry_mem_q [Entries];
  anhc_pkg::entry_t rd_data_q;
  logic             rd_valid_q;
  logic             rd_en;
  logic             mem_we;
  anhc_pkg::entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[wp_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= entry_mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en) begin
      rd_valid_q <= valid_q[rd_idx_q];
    end
  end

  // entry as seen by the compare: never-written entries read as zero
  logic                      ent_match;
  logic [anhc_pkg::MacW-1:0] ent_mac;
  logic                      local_dest;

  always_comb begin
    ent_match  = rd_valid_q ? (rd_data_q.ip == key_q) : (key_q == '0);
    ent_mac    = rd_valid_q ? rd_data_q.mac : '0;
    local_dest = ((item_i.peer_ip ^ local_ip_q) & subnet_mask_q) == '0;
  end

  always_comb begin
    state_d        = state_q;
    item_d         = item_q;
    key_d          = key_q;
    rd_idx_d       = rd_idx_q;
    cmp_idx_d      = cmp_idx_q;
    cmp_v_d        = cmp_v_q;
    wp_d           = wp_q;
    valid_d        = valid_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    wr_data.ip     = item_q.peer_ip;
    wr_data.mac    = item_q.peer_mac;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          item_d   = item_i;
          rd_idx_d = '0;
          cmp_v_d  = 1'b0;
          state_d  = StScan;
          if (item_i.operation == anhc_pkg::OpLearn) begin
            key_d = item_i.peer_ip;
          end else if (local_dest) begin
            key_d = item_i.peer_ip;
          end else begin
            key_d = gateway_ip_q;
          end
        end
      end
      StScan: begin
        // one read issued per cycle, compare follows in the next cycle
        rd_en     = 1'b1;
        cmp_v_d   = 1'b1;
        cmp_idx_d = rd_idx_q;
        if (rd_idx_q != LastIdx) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (cmp_v_q && (ent_match || cmp_idx_q == LastIdx)) begin
          state_d        = StIdle;
          cmp_v_d        = 1'b0;
          result_valid_d = 1'b1;
          result_d       = '0;
          if (item_q.operation == anhc_pkg::OpResolve) begin
            result_d.next_hop_ip    = key_q;
            result_d.hit            = ent_match;
            result_d.found_mac      = ent_match ? ent_mac : '0;
            result_d.request_needed = !ent_match;
          end else if (!ent_match && item_q.target_ip == local_ip_q) begin
            mem_we          = 1'b1;
            valid_d[wp_q]   = 1'b1;
            wp_d            = (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
            result_d.stored = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      rd_idx_q       <= '0;
      cmp_idx_q      <= '0;
      cmp_v_q        <= 1'b0;
      wp_q           <= '0;
      valid_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_idx_q       <= rd_idx_d;
      cmp_idx_q      <= cmp_idx_d;
      cmp_v_q        <= cmp_v_d;
      wp_q           <= wp_d;
      valid_q        <= valid_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    key_q    <= key_d;
    result_q <= result_d;
  end

  assign busy           = (state_q == StScan);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
